### rtl/core/grs_pkg.sv
// shared types and constants of the group reverse stream block
`default_nettype none

package grs_pkg;

  // field widths fixed by the item format
  localparam int ValueW = 32;
  localparam int CfgW   = 5;

  // default group buffer depth and reset group size
  localparam int MaxGroupDef = 16;
  localparam logic [CfgW-1:0] GroupSizeRst = CfgW'(2);

  // command that every cell of the row obeys in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cell_cmd_e;

  // controller states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  // control handed from the controller to the cell row
  typedef struct packed {
    cell_cmd_e           cmd;
    logic [ValueW-1:0]   push_value;
  } chain_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/grs_ifs.sv
// stream and configuration channel interfaces
`default_nettype none

// input item channel
interface grs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [grs_pkg::ValueW-1:0] value;
  logic                             end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink (input valid, input value, input end_of_list, output ready);
endinterface

// result item channel
interface grs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [grs_pkg::ValueW-1:0] out_value;
  logic                             last_of_run;
  logic                             list_done;

  modport source (output valid, output out_value, output last_of_run,
                  output list_done, input ready);
  modport sink (input valid, input out_value, input last_of_run,
                input list_done, output ready);
endinterface

// group size write channel
interface grs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [grs_pkg::CfgW-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/group_reverse_stream.sv
// top level of the group reverse stream block
`default_nettype none

// Values enter a row of MaxGroup cells, newest at the head. An item that
// does not close a group is taken at once unless an unload is running. An
// item that fills the group (count reaches group_size, held to 1..MaxGroup)
// or carries end_of_list starts an unload of all n buffered values, one per
// cycle while the output is not stalled, into the output register: popped
// from the head for a full group (reversed), read by count from the row for
// a partial final group (original order). No input is taken during the
// unload. A finished result may sit in the output register while new input
// is taken. group_size must be written on the configuration channel only
// while the block is idle; the block itself does not enforce this.
module group_reverse_stream #(
  parameter int MaxGroup = grs_pkg::MaxGroupDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  grs_in_if.sink     in_i,
  grs_out_if.source  out_o,
  grs_cfg_if.sink    cfg_i
);
  import grs_pkg::*;

  localparam int CntW = $clog2(MaxGroup + 1);
  localparam int IdxW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;

  state_e            st_q, st_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CfgW-1:0]   gs_q;
  logic              rev_q, rev_d;
  logic              eol_q, eol_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_done_q, out_done_d;

  logic [CntW-1:0]   k_eff;
  logic [CntW-1:0]   cnt_inc;
  logic [CntW-1:0]   cnt_dec;
  logic              in_xfer;
  logic              adv;
  logic              group_full;
  logic              final_val;
  chain_ctrl_t       ctrl;
  logic [ValueW-1:0] head_val, rd_val;

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GroupSizeRst;
    end else if (cfg_i.valid) begin
      gs_q <= cfg_i.data;
    end
  end

  // clamp group size to 1..MaxGroup
  always_comb begin
    if (gs_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(gs_q) > MaxGroup) begin
      k_eff = CntW'(MaxGroup);
    end else begin
      k_eff = CntW'(gs_q);
    end
  end

  assign cnt_inc    = cnt_q + CntW'(1);
  assign cnt_dec    = cnt_q - CntW'(1);
  assign in_xfer    = (st_q == ST_FILL) && in_i.valid;
  assign adv        = (st_q == ST_DRAIN) && (!out_valid_q || out_o.ready);
  assign group_full = (cnt_inc >= k_eff);
  assign final_val  = (cnt_q == CntW'(1));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_FILL: begin
        if (in_xfer && (group_full || in_i.end_of_list)) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv && final_val) begin
          st_d = ST_FILL;
        end
      end
      default: st_d = ST_FILL;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    cnt_d           = cnt_q;
    rev_d           = rev_q;
    eol_d           = eol_q;
    out_valid_d     = out_valid_q && !out_o.ready;
    out_value_d     = out_value_q;
    out_last_d      = out_last_q;
    out_done_d      = out_done_q;
    ctrl.cmd        = CMD_HOLD;
    ctrl.push_value = in_i.value;
    in_i.ready      = 1'b0;
    case (st_q)
      ST_FILL: begin
        in_i.ready = 1'b1;
        if (in_xfer) begin
          ctrl.cmd = CMD_PUSH;
          cnt_d    = cnt_inc;
          rev_d    = group_full;
          eol_d    = in_i.end_of_list;
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          ctrl.cmd    = rev_q ? CMD_POP : CMD_HOLD;
          cnt_d       = cnt_dec;
          out_valid_d = 1'b1;
          out_value_d = rev_q ? head_val : rd_val;
          out_last_d  = final_val;
          out_done_d  = final_val && eol_q;
        end
      end
      default: ;
    endcase
  end

  // cell row
  grs_chain #(
    .MaxGroup (MaxGroup)
  ) u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .rd_idx_i (cnt_dec[IdxW-1:0]),
    .head_o   (head_val),
    .rd_o     (rd_val)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_FILL;
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      eol_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      rev_q       <= rev_d;
      eol_q       <= eol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_value   = out_value_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.list_done   = out_done_q;

`ifndef SYNTHESIS
  // the row never holds a whole buffer while still filling
  a_fill_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> (int'(cnt_q) < MaxGroup))
    else $error("fill count reached buffer depth while filling");

  // an unload always has something left to send
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAIN) |-> (cnt_q != '0))
    else $error("unload with empty row");

  // end of sequence only on the last result of a run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("list_done without last_of_run");

  // a result is loaded only after an input transfer closed a group
  a_drain_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_FILL) && !in_xfer) |=> (st_q == ST_FILL))
    else $error("unload started without input transfer");
`endif

endmodule

`default_nettype wire

### rtl/core/grs_cell.sv
// one storage cell of the bidirectional shift row
`default_nettype none

module grs_cell (
  input  wire                        clk_i,
  input  grs_pkg::cell_cmd_e         cmd_i,
  input  wire [grs_pkg::ValueW-1:0]  from_left_i,
  input  wire [grs_pkg::ValueW-1:0]  from_right_i,
  output logic [grs_pkg::ValueW-1:0] value_o
);
  import grs_pkg::*;

  logic [ValueW-1:0] value_q, value_d;

  // push moves data away from the head, pop moves it toward the head
  always_comb begin
    case (cmd_i)
      CMD_PUSH: value_d = from_left_i;
      CMD_POP:  value_d = from_right_i;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

### rtl/core/grs_chain.sv
// row of cells holding the current group, newest value at the head
`default_nettype none

module grs_chain #(
  parameter int MaxGroup = grs_pkg::MaxGroupDef,
  localparam int IdxW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1
) (
  input  wire                        clk_i,
  input  grs_pkg::chain_ctrl_t       ctrl_i,
  input  wire [IdxW-1:0]             rd_idx_i,
  output logic [grs_pkg::ValueW-1:0] head_o,
  output logic [grs_pkg::ValueW-1:0] rd_o
);
  import grs_pkg::*;

  logic [ValueW-1:0] cell_val [MaxGroup];

  // neighbor links: head takes the pushed value, tail pops in zero
  for (genvar g = 0; g < MaxGroup; g++) begin : g_cell
    logic [ValueW-1:0] left_val, right_val;

    if (g == 0) begin : g_head
      assign left_val = ctrl_i.push_value;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == MaxGroup - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    grs_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (ctrl_i.cmd),
      .from_left_i  (left_val),
      .from_right_i (right_val),
      .value_o      (cell_val[g])
    );
  end

  // head tap for reversed unload, indexed tap for in-order unload
  assign head_o = cell_val[0];
  assign rd_o   = cell_val[rd_idx_i];

endmodule

`default_nettype wire
